[rtl/pctrc_pkg.sv]
// Shared types and constants for the PC trace run compressor.
`default_nettype none

package pctrc_pkg;

  localparam int unsigned AddrWidth = 32;
  localparam int unsigned StrideWidth = 8;
  localparam int unsigned RunWidth = 16;
  localparam int unsigned CfgIdxWidth = 2;

  typedef enum logic [0:0] {
    OP_SAMPLE = 1'b0,
    OP_FLUSH  = 1'b1
  } opcode_t;

  typedef enum logic [CfgIdxWidth-1:0] {
    CFG_SKIP_LOW  = 2'd0,
    CFG_SKIP_HIGH = 2'd1,
    CFG_PC_STRIDE = 2'd2,
    CFG_MAX_RUN   = 2'd3
  } cfg_idx_t;

  localparam logic [AddrWidth-1:0] SkipLowReset = 32'h0f00_0000;
  localparam logic [AddrWidth-1:0] SkipHighReset = 32'h0fff_ffff;
  localparam logic [StrideWidth-1:0] PcStrideReset = 8'd4;
  localparam logic [RunWidth-1:0] MaxRunReset = 16'hffff;

  typedef struct packed {
    logic [AddrWidth-1:0]   skip_low;
    logic [AddrWidth-1:0]   skip_high;
    logic [StrideWidth-1:0] pc_stride;
    logic [RunWidth-1:0]    max_run;
  } cfg_t;

  typedef struct packed {
    logic [RunWidth-1:0]  run_count;
    logic [AddrWidth-1:0] start_address;
  } record_t;

endpackage

`default_nettype wire

[rtl/pc_trace_run_compressor.sv]
// Top level of the PC trace run compressor: channels, config registers, pipeline.
//
//  channel  dir  handshake                  payload
//  s_axis   in   s_axis_tvalid/tready       tdata = pc, tuser = opcode
//  m_axis   out  m_axis_tvalid/tready       tdata = start_address, run_count
//  cfg      in   cfg_valid/cfg_ready        cfg_index, cfg_data
//
// One transaction per cycle sustained while m_axis is not stalled: an input
// register feeds the run decision logic, which writes a result register in the
// same cycle.
// rst (synchronous) restores config defaults and the empty run state.
// A stalled m_axis holds the input register; s_axis_tready drops only once
// both the input and result registers are full.
`default_nettype none

module pc_trace_run_compressor
  import pctrc_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  input  wire logic [AddrWidth-1:0]   s_axis_tdata,  // [31:0] pc
  input  wire logic                   s_axis_tuser,  // [0] opcode
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  output logic [47:0]                 m_axis_tdata,  // [31:0] start_address, [47:32] run_count
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CfgIdxWidth-1:0] cfg_index,
  input  wire logic [AddrWidth-1:0]   cfg_data
);

  cfg_t cfg;

  logic                 in_valid;
  opcode_t              in_op;
  logic [AddrWidth-1:0] in_pc;

  logic    s_fire, proc_fire;
  logic    emit;
  record_t rec;

  logic    out_valid;
  record_t out_rec;

  // config writes are always taken
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.skip_low  <= SkipLowReset;
      cfg.skip_high <= SkipHighReset;
      cfg.pc_stride <= PcStrideReset;
      cfg.max_run   <= MaxRunReset;
    end else if (cfg_valid) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_SKIP_LOW:  cfg.skip_low  <= cfg_data;
        CFG_SKIP_HIGH: cfg.skip_high <= cfg_data;
        CFG_PC_STRIDE: cfg.pc_stride <= cfg_data[StrideWidth-1:0];
        CFG_MAX_RUN:   cfg.max_run   <= cfg_data[RunWidth-1:0];
        default: ;
      endcase
    end
  end

  // item moves from input register to result stage when the result slot frees
  assign proc_fire     = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || proc_fire;
  assign s_fire        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_fire) begin
      in_valid <= 1'b1;
    end else if (proc_fire) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_fire) begin
      in_op <= opcode_t'(s_axis_tuser);
      in_pc <= s_axis_tdata;
    end
  end

  pctrc_core u_core (
    .clk  (clk),
    .rst  (rst),
    .step (proc_fire),
    .op   (in_op),
    .pc   (in_pc),
    .cfg  (cfg),
    .emit (emit),
    .rec  (rec)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (proc_fire) begin
      out_valid <= emit;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc_fire && emit) begin
      out_rec <= rec;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_rec;

`ifndef SYNTHESIS
  a_emit_lands: assert property (@(posedge clk) disable iff (rst)
    proc_fire && emit |=> m_axis_tvalid)
    else $error("emitted record not presented");

  a_ready_when_free: assert property (@(posedge clk) disable iff (rst)
    !in_valid |-> s_axis_tready)
    else $error("input stalled with empty input register");

  a_out_nonzero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[47:32] != '0))
    else $error("record with zero run count");
`endif

endmodule

`default_nettype wire

[rtl/pctrc_core.sv]
// Run tracking state and per-item decision logic.
`default_nettype none

module pctrc_core
  import pctrc_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 step,
  input  wire opcode_t              op,
  input  wire logic [AddrWidth-1:0] pc,
  input  wire cfg_t                 cfg,
  output logic                      emit,
  output record_t                   rec
);

  logic [AddrWidth-1:0] previous_address, previous_address_next;
  logic [AddrWidth-1:0] run_start, run_start_next;
  logic [RunWidth-1:0]  run_len, run_len_next;
  logic                 empty, empty_next;

  logic                 in_window;
  logic [AddrWidth-1:0] seq_pc;
  logic                 is_seq;

  assign in_window = (pc >= cfg.skip_low) && (pc < cfg.skip_high);
  assign seq_pc    = previous_address + {{(AddrWidth-StrideWidth){1'b0}}, cfg.pc_stride};
  // zero max_run never passes this compare, so every later address outside the skip window closes the run
  assign is_seq    = (pc == seq_pc) && (run_len < cfg.max_run);

  assign rec.start_address = run_start;
  assign rec.run_count     = run_len;

  always_comb begin
    emit                  = 1'b0;
    previous_address_next = previous_address;
    run_start_next        = run_start;
    run_len_next          = run_len;
    empty_next            = empty;
    if (step) begin
      unique case (op)
        OP_FLUSH: begin
          emit                  = !empty && (run_len != '0);
          previous_address_next = '0;
          run_start_next        = '0;
          run_len_next          = '0;
          empty_next            = 1'b1;
        end
        OP_SAMPLE: begin
          if (!in_window) begin
            previous_address_next = pc;
            priority if (empty) begin
              run_start_next = pc;
              run_len_next   = RunWidth'(1);
              empty_next     = 1'b0;
            end else if (is_seq) begin
              run_len_next = run_len + RunWidth'(1);
            end else begin
              emit           = 1'b1;
              run_start_next = pc;
              run_len_next   = RunWidth'(1);
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_address <= '0;
      run_start        <= '0;
      run_len          <= '0;
      empty            <= 1'b1;
    end else begin
      previous_address <= previous_address_next;
      run_start        <= run_start_next;
      run_len          <= run_len_next;
      empty            <= empty_next;
    end
  end

`ifndef SYNTHESIS
  a_empty_len: assert property (@(posedge clk) disable iff (rst)
    empty == (run_len == '0))
    else $error("run length disagrees with empty flag");

  a_emit_nonzero: assert property (@(posedge clk) disable iff (rst)
    emit |-> (run_len != '0) && !empty)
    else $error("record emitted with no pending run");

  a_flush_clears: assert property (@(posedge clk) disable iff (rst)
    step && (op == OP_FLUSH) |=> empty)
    else $error("flush did not clear the run");
`endif

endmodule

`default_nettype wire

[tb/sv/tb_pc_trace_run_compressor.sv]
// Self-checking testbench for the PC trace run compressor.
`default_nettype none

module tb_pc_trace_run_compressor;
  import pctrc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // ---------------------------------------------------------------------------
  // DUT signals
  // ---------------------------------------------------------------------------
  logic                   clk;
  logic                   rst;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [AddrWidth-1:0]   s_axis_tdata;   // [31:0] pc
  logic                   s_axis_tuser;   // [0] opcode
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [47:0]            m_axis_tdata;   // [31:0] start_address, [47:32] run_count
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CfgIdxWidth-1:0] cfg_index;
  logic [AddrWidth-1:0]   cfg_data;

  pc_trace_run_compressor uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  // 10 ns clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Shared testbench state
  // ---------------------------------------------------------------------------
  int      errors = 0;
  record_t pending_records[$];  // records the compressor still owes us, oldest first

  // Idle control: when an *_idle_on flag is clear that side runs back to back.
  bit      tx_idle_on = 1'b1;
  bit      rx_idle_on = 1'b1;

  // Receiver hold-off. A trigger on hold_go starts it; the hold process then
  // counts hold_cycles falling edges and masks tready meanwhile. The receiver
  // loop itself never sees it.
  int      hold_cycles = 0;
  event    hold_go;
  logic    rx_ready;
  logic    rx_hold;
  assign m_axis_tready = rx_ready && !rx_hold;

  // Our own copy of the config registers, tracked from every cfg transaction.
  logic [AddrWidth-1:0]   win_lo   = SkipLowReset;
  logic [AddrWidth-1:0]   win_hi   = SkipHighReset;
  logic [StrideWidth-1:0] stride   = PcStrideReset;
  logic [RunWidth-1:0]    max_len  = MaxRunReset;

  // Run tracker state: the run being built and the last kept address.
  logic [AddrWidth-1:0]   last_pc    = '0;
  logic [AddrWidth-1:0]   run_base   = '0;
  logic [RunWidth-1:0]    run_len    = '0;
  bit                     trace_idle = 1'b1;  // no address kept since reset/flush

  // Items that actually touch the run state (flushes and kept samples);
  // addresses dropped by the excluded window don't count.
  int                     kept_items = 0;

  // ---------------------------------------------------------------------------
  // Run tracker: mirrors the compressor for one accepted input transaction and
  // queues the record it must emit, if any.
  // ---------------------------------------------------------------------------
  task automatic track_run(input opcode_t op, input logic [AddrWidth-1:0] pc);
    record_t                rec;
    logic [AddrWidth-1:0]   next_pc;
    rec = '{run_count: run_len, start_address: run_base};
    next_pc = last_pc + AddrWidth'(stride);
    if (op == OP_FLUSH) begin
      // pc is ignored; a flush on an empty tracker emits nothing
      if (!trace_idle && run_len != '0) pending_records.push_back(rec);
      last_pc    = '0;
      run_base   = '0;
      run_len    = '0;
      trace_idle = 1'b1;
      kept_items++;
      return;
    end
    // excluded window is [lo, hi); lo >= hi means nothing is excluded
    if (pc >= win_lo && pc < win_hi) return;
    kept_items++;
    if (trace_idle) begin
      run_base   = pc;
      run_len    = RunWidth'(1);
      trace_idle = 1'b0;
    end else if (pc == next_pc && run_len < max_len) begin
      run_len = run_len + 1'b1;
    end else begin
      // break in sequence, or run already at max_run (zero acts like one)
      pending_records.push_back(rec);
      run_base = pc;
      run_len  = RunWidth'(1);
    end
    last_pc = pc;
  endtask

  // ---------------------------------------------------------------------------
  // Sender: one input transaction. Entered and left at a falling edge; tvalid
  // stays high on exit so back-to-back items follow without a gap.
  // ---------------------------------------------------------------------------
  task automatic send_item(input opcode_t op, input logic [AddrWidth-1:0] pc);
    int gap;
    gap = tx_idle_on ? $urandom_range(0, 12) : 0;
    if (gap > 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = pc;
    s_axis_tuser  = op;
    do @(posedge clk); while (!s_axis_tready);
    track_run(op, pc);
    @(negedge clk);
  endtask

  task automatic send_sample(input logic [AddrWidth-1:0] pc);
    send_item(OP_SAMPLE, pc);
  endtask

  task automatic send_flush();
    send_item(OP_FLUSH, $urandom);
  endtask

  // Drop tvalid, drain every owed record, then keep waiting on the pipeline
  // so that items that emit nothing have also retired.
  task automatic wait_idle();
    s_axis_tvalid = 1'b0;
    while (pending_records.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // One config transaction; only called while the block is idle.
  task automatic write_cfg(input cfg_idx_t idx, input logic [AddrWidth-1:0] data);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_SKIP_LOW:  win_lo  = data;
      CFG_SKIP_HIGH: win_hi  = data;
      CFG_PC_STRIDE: stride  = data[StrideWidth-1:0];
      CFG_MAX_RUN:   max_len = data[RunWidth-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic set_registers(input logic [AddrWidth-1:0] lo, input logic [AddrWidth-1:0] hi,
                               input logic [StrideWidth-1:0] stp, input logic [RunWidth-1:0] mx);
    wait_idle();
    write_cfg(CFG_SKIP_LOW, lo);
    write_cfg(CFG_SKIP_HIGH, hi);
    write_cfg(CFG_PC_STRIDE, AddrWidth'(stp));
    write_cfg(CFG_MAX_RUN, AddrWidth'(mx));
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: draws a stall before each record, then holds tready high until
  // a transaction happens.
  // ---------------------------------------------------------------------------
  initial begin
    int stall;
    rx_ready = 1'b0;
    @(negedge clk);
    forever begin
      stall = rx_idle_on ? $urandom_range(0, 12) : 0;
      if (stall > 0) begin
        rx_ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      rx_ready = 1'b1;
      do @(posedge clk); while (!(m_axis_tvalid && m_axis_tready));
      @(negedge clk);
    end
  end

  // Long hold-off, counted here so that the sender keeps pushing meanwhile.
  initial begin
    rx_hold = 1'b0;
    forever begin
      @(hold_go);
      rx_hold = 1'b1;
      repeat (hold_cycles) @(negedge clk);
      rx_hold = 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Record checker: every output transaction against the oldest expectation.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    record_t got;
    record_t want;
    got = record_t'(m_axis_tdata);
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_records.size() == 0) begin
        $display("%0t: unexpected record: expected none, actual start_address %h run_count %0d",
                 $time, got.start_address, got.run_count);
        errors++;
      end else begin
        want = pending_records.pop_front();
        if (got.start_address !== want.start_address) begin
          $display("%0t: start_address mismatch: expected %h, actual %h",
                   $time, want.start_address, got.start_address);
          errors++;
        end
        if (got.run_count !== want.run_count) begin
          $display("%0t: run_count mismatch: expected %0d, actual %0d",
                   $time, want.run_count, got.run_count);
          errors++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset values of the registers: window bounds, stride 4, address wrap,
  // flush handling, address field extremes.
  task automatic test_default_registers();
    send_flush();                  // flush while empty: nothing
    send_sample(32'h0000_0000);    // first kept address: run opens silently
    send_sample(32'h0000_0004);
    send_sample(32'h0000_0008);
    send_sample(32'h0f00_0000);    // lower bound is inclusive: dropped
    send_sample(32'h0fff_fffe);    // inside window: dropped
    send_sample(32'h0000_000c);    // still sequential, drops didn't move last pc
    send_sample(32'h0fff_ffff);    // upper bound is exclusive: kept, breaks run
    send_sample(32'h1000_0003);
    send_sample(32'hffff_fffc);
    send_sample(32'h0000_0000);    // sequential across the 2^32 wrap
    send_sample(32'hffff_ffff);
    send_item(OP_FLUSH, 32'h5555_aaaa);  // pc ignored on flush
    send_flush();
    send_sample(32'h0eff_ffff);    // just below the window
    send_flush();
  endtask

  // Register corner cases: empty and inverted windows, zero stride, zero and
  // tiny max_run, largest stride, window covering nearly everything.
  task automatic test_register_corners();
    set_registers(32'h0000_0100, 32'h0000_0100, 8'd0, 16'd0);
    send_sample(32'h0000_0100);    // empty window keeps it
    send_sample(32'h0000_0100);    // max_run 0 behaves like 1: emits
    send_sample(32'h0000_0100);
    send_flush();

    set_registers(32'h0000_0200, 32'h0000_0100, 8'd0, 16'd3);
    repeat (5) send_sample(32'h0000_0180);  // repeats are sequential with stride 0
    send_flush();

    set_registers(32'h0000_0000, 32'hffff_ffff, 8'hff, 16'd1);
    send_sample(32'h0000_0000);    // dropped
    send_sample(32'h1234_5678);    // dropped
    send_sample(32'hffff_ffff);    // only address outside the window
    send_sample(32'hffff_ffff);
    send_flush();

    set_registers(32'hffff_ffff, 32'h0000_0000, 8'hff, 16'hffff);
    send_sample(32'h0000_0010);
    send_sample(32'h0000_010f);    // stride 255
    send_flush();
  endtask

  // Long receiver hold-off with a back-to-back sender: every sample breaks
  // the run, so records pile up until s_axis_tready drops.
  task automatic test_output_backpressure();
    bit saved_tx;
    saved_tx = tx_idle_on;
    set_registers(SkipLowReset, SkipHighReset, PcStrideReset, MaxRunReset);
    tx_idle_on  = 1'b0;
    hold_cycles = 80;
    -> hold_go;
    for (int i = 0; i < 40; i++) send_sample(32'h0001_0000 * (i + 1));
    send_flush();
    tx_idle_on = saved_tx;
    wait_idle();
  endtask

  // Random traffic over several register settings. Mostly sequential runs
  // with random starts and lengths, sprinkled with dropped addresses,
  // flushes and stray addresses.
  task automatic test_random_traffic();
    int                   target;
    int                   pick;
    int                   len;
    logic [AddrWidth-1:0] base;
    logic [AddrWidth-1:0] lo;
    for (int phase = 0; phase < 6; phase++) begin
      lo = $urandom;
      case (phase)
        0: set_registers(SkipLowReset, SkipHighReset, PcStrideReset, MaxRunReset);
        1: set_registers(lo, lo + $urandom_range(16, 65536), 8'd0, 16'd1);
        2: set_registers(32'h0000_0000, 32'h0000_0100, 8'd4, 16'd2);
        3: set_registers(lo, lo + $urandom_range(16, 65536), 8'($urandom),
                         16'($urandom_range(1, 8)));
        4: set_registers(32'hffff_ff00, 32'hffff_ffff, 8'hff, 16'($urandom));
        default: set_registers(lo, $urandom, 8'($urandom), 16'($urandom_range(3, 40)));
      endcase
      target = kept_items + 270;
      while (kept_items < target) begin
        // stretches with and without idling on either side
        if ($urandom_range(0, 30) == 0) tx_idle_on = !tx_idle_on;
        if ($urandom_range(0, 30) == 0) rx_idle_on = !rx_idle_on;
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
          // sequential run
          if (max_len <= 8) len = $urandom_range(1, 2 * max_len + 2);
          else if ($urandom_range(0, 39) == 0) len = $urandom_range(60, 200);
          else len = $urandom_range(1, 20);
          case ($urandom_range(0, 15))
            0, 1: base = win_lo - AddrWidth'(stride) * $urandom_range(1, 4);  // run into window
            2:    base = 32'hffff_ffff - AddrWidth'(stride) * $urandom_range(0, 4); // wrap
            default: base = $urandom;
          endcase
          for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 14) == 0 && win_lo < win_hi)
              send_sample(win_lo + ($urandom % (win_hi - win_lo)));
            send_sample(base + AddrWidth'(stride) * i);
          end
        end else if (pick < 80) begin
          send_flush();
        end else if (pick < 90 && win_lo < win_hi) begin
          send_sample(win_lo + ($urandom % (win_hi - win_lo)));
        end else begin
          send_sample($urandom);
        end
      end
    end
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = OP_SAMPLE;
    cfg_valid     = 1'b0;
    cfg_index     = CFG_SKIP_LOW;
    cfg_data      = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_default_registers();
    test_register_corners();
    test_output_backpressure();
    test_random_traffic();

    // drain, then wait on to catch any stray record
    wait_idle();
    repeat (10) @(negedge clk);
    if (errors == 0) begin
      $display("tb_pc_trace_run_compressor: done, clean");
    end else begin
      $display("tb_pc_trace_run_compressor: done, errors");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run of this stimulus.
  initial begin
    #5_000_000;
    $display("tb_pc_trace_run_compressor: done, errors");
    $finish;
  end

endmodule

`default_nettype wire
